// ===== sv/int8_gemv_requant_defines.svh =====
// assertion macros for the int8 gemv requant block
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef INT8_GEMV_REQUANT_DEFINES_SVH
`define INT8_GEMV_REQUANT_DEFINES_SVH

// same-cycle implication
`define IGR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IGR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/igr_pkg.sv =====
// shared types and constants of the int8 gemv requant block
// no dependencies
package igr_pkg;

    localparam int LANES    = 4;
    localparam int ELEM_W   = 8;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int ACC_W    = 28;
    localparam int SCALE_W  = 32;
    localparam int BIAS_W   = 40;
    localparam int SIX_W    = 31;
    localparam int SLOPE_W  = 32;
    localparam int FRAC_W   = 24;
    localparam int V_W      = 61;
    localparam int MAG_W    = 60;
    localparam int LO_W     = 32;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int Q_W      = 45;
    localparam int RES_W    = 8;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 4;

    localparam logic [SIX_W-1:0] SIX_RESET = 31'h0600_0000;
    localparam logic [6:0]       SAT_MAX   = 7'd127;

    localparam logic [1:0] REG_BIAS_EN = 2'd0;
    localparam logic [1:0] REG_ACT     = 2'd1;
    localparam logic [1:0] REG_SIX     = 2'd2;
    localparam logic [1:0] REG_SLOPE   = 2'd3;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RELU  = 2'd1,
        ACT_RELU6 = 2'd2,
        ACT_LEAKY = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        RQ_IDLE,
        RQ_BIAS,
        RQ_ACT,
        RQ_PROD,
        RQ_ROUND,
        RQ_OUT
    } t_rq_state;

    typedef struct packed {
        logic                      bias_enable;
        t_act                      act_mode;
        logic [SIX_W-1:0]          six_limit;
        logic signed [SLOPE_W-1:0] leaky_slope;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic signed [ACC_W-1:0]   acc;
        logic signed [SCALE_W-1:0] scale;
        logic signed [BIAS_W-1:0]  bias;
    } t_job;

    typedef struct packed {
        logic take;
        logic push;
    } t_rq_ctl;

endpackage

// ===== sv/igr_in_if.sv =====
// input channel of the int8 gemv requant block: valid, ready and one row slice
// depends on igr_pkg
interface igr_in_if;
    import igr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ELEM_W-1:0]  mat_elem0;
    logic signed [ELEM_W-1:0]  mat_elem1;
    logic signed [ELEM_W-1:0]  mat_elem2;
    logic signed [ELEM_W-1:0]  mat_elem3;
    logic signed [ELEM_W-1:0]  vec_elem0;
    logic signed [ELEM_W-1:0]  vec_elem1;
    logic signed [ELEM_W-1:0]  vec_elem2;
    logic signed [ELEM_W-1:0]  vec_elem3;
    logic                      row_end;
    logic signed [SCALE_W-1:0] row_scale;
    logic signed [BIAS_W-1:0]  row_bias;

    modport source (
        output valid, mat_elem0, mat_elem1, mat_elem2, mat_elem3,
        output vec_elem0, vec_elem1, vec_elem2, vec_elem3,
        output row_end, row_scale, row_bias,
        input  ready
    );

    modport sink (
        input  valid, mat_elem0, mat_elem1, mat_elem2, mat_elem3,
        input  vec_elem0, vec_elem1, vec_elem2, vec_elem3,
        input  row_end, row_scale, row_bias,
        output ready
    );
endinterface

// ===== sv/igr_out_if.sv =====
// output channel of the int8 gemv requant block: valid, ready and the result
// depends on igr_pkg
interface igr_out_if;
    import igr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;

    modport source (output valid, result_value, input ready);
    modport sink   (input valid, result_value, output ready);
endinterface

// ===== sv/igr_lane.sv =====
// one multiply lane: signed int8 matrix element times vector element
// depends on igr_pkg
module igr_lane (
    input  logic signed [igr_pkg::ELEM_W-1:0] i_mat,
    input  logic signed [igr_pkg::ELEM_W-1:0] i_vec,
    output logic signed [igr_pkg::PROD_W-1:0] o_prod
);
    import igr_pkg::*;

    assign o_prod = i_mat * i_vec;
endmodule

// ===== sv/igr_merge.sv =====
// merge stage: sums the lane products into the dot accumulator and
// hands a finished row to the requant sequencer; depends on igr_pkg
module igr_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [igr_pkg::PROD_W-1:0]  i_prod [igr_pkg::LANES],
    input  logic                               i_accept,
    input  logic                               i_row_end,
    input  logic signed [igr_pkg::SCALE_W-1:0] i_row_scale,
    input  logic signed [igr_pkg::BIAS_W-1:0]  i_row_bias,
    input  logic                               i_take,
    output igr_pkg::t_job                      o_job
);
    import igr_pkg::*;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_sum;
    t_job                    r_job;

    always_comb begin
        w_sum = r_acc;
        for (int i = 0; i < LANES; i++) begin
            w_sum = w_sum + ACC_W'(i_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_job.valid <= 1'b0;
        end else begin
            if (i_accept && i_row_end) begin
                r_acc       <= '0;
                r_job.valid <= 1'b1;
            end else begin
                if (i_accept) begin
                    r_acc <= w_sum;
                end
                if (i_take) begin
                    r_job.valid <= 1'b0;
                end
            end
        end
        if (i_accept && i_row_end) begin
            r_job.acc   <= w_sum;
            r_job.scale <= i_row_scale;
            r_job.bias  <= i_row_bias;
        end
    end

    assign o_job = r_job;
endmodule

// ===== sv/igr_requant.sv =====
// requant sequencer: scale, bias, activation, rounding and saturation of one row
// depends on igr_pkg
module igr_requant (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  igr_pkg::t_job                 i_job,
    input  igr_pkg::t_cfg                 i_cfg,
    input  logic                          i_out_free,
    output igr_pkg::t_rq_ctl              o_ctl,
    output logic signed [igr_pkg::RES_W-1:0] o_result
);
    import igr_pkg::*;

    t_rq_state r_state;
    t_rq_state n_state;

    logic signed [ACC_W+SCALE_W-1:0] w_prod;
    logic signed [V_W-1:0]           w_bias_add;
    logic signed [V_W-1:0]           w_val;
    logic                            w_leaky;
    logic                            w_neg;
    logic [MAG_W-1:0]                w_mag;
    logic [SLOPE_W-1:0]              w_a;
    logic [LO_W+SLOPE_W:0]           w_s1;
    logic [V_W-1:0]                  w_rnd;
    logic [Q_W-1:0]                  w_q;
    logic [6:0]                      w_sat;
    logic signed [RES_W-1:0]         w_res;

    logic signed [V_W-1:0]       r_v;
    logic signed [BIAS_W-1:0]    r_bias;
    logic [MAG_W-1:0]            r_mag;
    logic                        r_neg;
    logic                        r_leaky;
    logic [SLOPE_W-1:0]          r_a;
    logic [LO_W+SLOPE_W-1:0]     r_plo;
    logic [HI_W+SLOPE_W-1:0]     r_phi;
    logic signed [RES_W-1:0]     r_res;

    assign w_prod = i_job.acc * i_job.scale;

    always_comb begin
        w_bias_add = '0;
        if (i_cfg.bias_enable) begin
            w_bias_add = V_W'(r_bias);
        end
    end

    // activation on the biased value
    always_comb begin
        w_val   = r_v;
        w_leaky = 1'b0;
        case (i_cfg.act_mode)
            ACT_NONE: begin
                w_val = r_v;
            end
            ACT_RELU: begin
                if (r_v[V_W-1]) begin
                    w_val = '0;
                end
            end
            ACT_RELU6: begin
                if (r_v[V_W-1]) begin
                    w_val = '0;
                end else if (r_v > $signed(V_W'(i_cfg.six_limit))) begin
                    w_val = $signed(V_W'(i_cfg.six_limit));
                end
            end
            ACT_LEAKY: begin
                w_leaky = r_v[V_W-1];
            end
            default: begin
                w_val = r_v;
            end
        endcase
        w_mag = w_val[V_W-1] ? MAG_W'(-w_val) : MAG_W'(w_val);
        w_neg = w_leaky ? ~i_cfg.leaky_slope[SLOPE_W-1] : w_val[V_W-1];
        w_a   = i_cfg.leaky_slope[SLOPE_W-1] ? $unsigned(-i_cfg.leaky_slope)
                                             : $unsigned(i_cfg.leaky_slope);
    end

    // rounding half away from zero and saturation
    always_comb begin
        w_s1  = (LO_W+SLOPE_W+1)'({r_phi[2*FRAC_W-LO_W-1:0], {LO_W{1'b0}}})
              + (LO_W+SLOPE_W+1)'(r_plo)
              + ((LO_W+SLOPE_W+1)'(1) << (2*FRAC_W-1));
        w_rnd = {1'b0, r_mag} + (V_W'(1) << (FRAC_W-1));
        if (r_leaky) begin
            w_q = Q_W'(r_phi[HI_W+SLOPE_W-1:2*FRAC_W-LO_W])
                + Q_W'(w_s1[LO_W+SLOPE_W:2*FRAC_W]);
        end else begin
            w_q = Q_W'(w_rnd[V_W-1:FRAC_W]);
        end
        w_sat = (w_q > Q_W'(SAT_MAX)) ? SAT_MAX : w_q[6:0];
        w_res = r_neg ? -$signed({1'b0, w_sat}) : $signed({1'b0, w_sat});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            RQ_IDLE: begin
                if (i_job.valid) begin
                    n_state = RQ_BIAS;
                end
            end
            RQ_BIAS:  n_state = RQ_ACT;
            RQ_ACT:   n_state = RQ_PROD;
            RQ_PROD:  n_state = RQ_ROUND;
            RQ_ROUND: n_state = RQ_OUT;
            RQ_OUT: begin
                if (i_out_free) begin
                    n_state = RQ_IDLE;
                end
            end
            default:  n_state = RQ_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.take = 1'b0;
        o_ctl.push = 1'b0;
        case (r_state)
            RQ_IDLE: o_ctl.take = i_job.valid;
            RQ_OUT:  o_ctl.push = i_out_free;
            default: begin
                o_ctl.take = 1'b0;
                o_ctl.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RQ_IDLE: begin
                r_v    <= V_W'(w_prod);
                r_bias <= i_job.bias;
            end
            RQ_BIAS: begin
                r_v <= r_v + w_bias_add;
            end
            RQ_ACT: begin
                r_mag   <= w_mag;
                r_neg   <= w_neg;
                r_leaky <= w_leaky;
                r_a     <= w_a;
            end
            RQ_PROD: begin
                r_plo <= (LO_W+SLOPE_W)'(r_mag[LO_W-1:0]) * (LO_W+SLOPE_W)'(r_a);
                r_phi <= (HI_W+SLOPE_W)'(r_mag[MAG_W-1:LO_W]) * (HI_W+SLOPE_W)'(r_a);
            end
            RQ_ROUND: begin
                r_res <= w_res;
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_res;
endmodule

// ===== sv/int8_gemv_requant.sv =====
// top level of the int8 gemv requant block: lanes, merge, requant, apb registers
// depends on igr_pkg, igr_in_if, igr_out_if, igr_lane, igr_merge, igr_requant
//
//  port     dir   contents
//  i_in     sink  4 matrix + 4 vector int8 elements, row_end, row_scale, row_bias
//  o_out    src   result_value, one transaction per row
//  apb      slave bias_enable, act_mode, six_limit, leaky_slope at 0x0/0x4/0x8/0xc
//
// row items are taken one per cycle while ready, the four products summed combinationally
// a row-end item hands its sum to the requant sequencer: bias, act, prod, round, out
// the sequencer takes a new row only from idle; transactions wait while a row is queued
// a stall on o_out holds the sequencer, and the input once a second row has ended
// synchronous active-low reset clears accumulator, control and registers
`include "int8_gemv_requant_defines.svh"

module int8_gemv_requant (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    igr_in_if.sink                        i_in,
    igr_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [igr_pkg::PADDR_W-1:0]   paddr,
    input  logic [igr_pkg::DATA_W-1:0]    pwdata,
    output logic [igr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import igr_pkg::*;

    logic signed [ELEM_W-1:0] w_mat  [LANES];
    logic signed [ELEM_W-1:0] w_vec  [LANES];
    logic signed [PROD_W-1:0] w_prod [LANES];
    logic                     w_accept;
    logic                     w_out_free;
    t_job                     w_job;
    t_rq_ctl                  w_ctl;
    logic signed [RES_W-1:0]  w_result;
    t_cfg                     w_cfg;

    logic                      r_bias_enable;
    t_act                      r_act_mode;
    logic [SIX_W-1:0]          r_six_limit;
    logic signed [SLOPE_W-1:0] r_leaky_slope;
    logic                      r_out_valid;
    logic signed [RES_W-1:0]   r_out_data;

    assign w_mat[0] = i_in.mat_elem0;
    assign w_mat[1] = i_in.mat_elem1;
    assign w_mat[2] = i_in.mat_elem2;
    assign w_mat[3] = i_in.mat_elem3;
    assign w_vec[0] = i_in.vec_elem0;
    assign w_vec[1] = i_in.vec_elem1;
    assign w_vec[2] = i_in.vec_elem2;
    assign w_vec[3] = i_in.vec_elem3;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        igr_lane u_lane (
            .i_mat  (w_mat[g]),
            .i_vec  (w_vec[g]),
            .o_prod (w_prod[g])
        );
    end

    assign i_in.ready = !w_job.valid || w_ctl.take;
    assign w_accept   = i_in.valid && i_in.ready;

    igr_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_prod      (w_prod),
        .i_accept    (w_accept),
        .i_row_end   (i_in.row_end),
        .i_row_scale (i_in.row_scale),
        .i_row_bias  (i_in.row_bias),
        .i_take      (w_ctl.take),
        .o_job       (w_job)
    );

    assign w_cfg.bias_enable = r_bias_enable;
    assign w_cfg.act_mode    = r_act_mode;
    assign w_cfg.six_limit   = r_six_limit;
    assign w_cfg.leaky_slope = r_leaky_slope;

    assign w_out_free = !r_out_valid || o_out.ready;

    igr_requant u_requant (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job),
        .i_cfg      (w_cfg),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_result   (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.push) begin
            r_out_data <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_data;

    // apb registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_enable <= 1'b0;
            r_act_mode    <= ACT_NONE;
            r_six_limit   <= SIX_RESET;
            r_leaky_slope <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_BIAS_EN: r_bias_enable <= pwdata[0];
                REG_ACT:     r_act_mode    <= t_act'(pwdata[1:0]);
                REG_SIX:     r_six_limit   <= pwdata[SIX_W-1:0];
                REG_SLOPE:   r_leaky_slope <= $signed(pwdata[SLOPE_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BIAS_EN: prdata = DATA_W'(r_bias_enable);
            REG_ACT:     prdata = DATA_W'(r_act_mode);
            REG_SIX:     prdata = DATA_W'(r_six_limit);
            REG_SLOPE:   prdata = DATA_W'($unsigned(r_leaky_slope));
            default:     prdata = '0;
        endcase
    end

    `IGR_ASSERT_NXT(a_row_end_queued, w_accept && i_in.row_end, w_job.valid,
        "row end transaction did not queue a requant job")
    `IGR_ASSERT_IMP(a_no_job_overwrite, w_accept && i_in.row_end,
        !w_job.valid || w_ctl.take, "queued requant job overwritten")
    `IGR_ASSERT_IMP(a_no_minus_128, o_out.valid, o_out.result_value != 8'sh80,
        "result outside the saturated range")
endmodule

// ===== sim/testbench.sv =====
// self-checking bench for int8_gemv_requant: random and directed row slices, apb setup
// depends on igr_pkg, igr_in_if, igr_out_if and the int8_gemv_requant top level
`timescale 1ns / 1ps

module testbench;
    import igr_pkg::*;

    typedef struct packed {
        logic [LANES-1:0][ELEM_W-1:0] mat;
        logic [LANES-1:0][ELEM_W-1:0] vec;
        logic                         row_end;
        logic signed [SCALE_W-1:0]    scale;
        logic signed [BIAS_W-1:0]     bias;
    } t_slice;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    igr_in_if  in_ch ();
    igr_out_if out_ch ();

    int8_gemv_requant dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // register copies and the running dot product
    logic                      bias_en_m = 1'b0;
    t_act                      act_m     = ACT_NONE;
    logic [SIX_W-1:0]          six_m     = SIX_RESET;
    logic signed [SLOPE_W-1:0] slope_m   = '0;
    logic [ACC_W-1:0]          acc_m     = '0;

    t_slice                  pending_slices [$];
    logic signed [RES_W-1:0] row_results_due [$];

    t_slice                  cur_slice = '0;
    t_slice                  seen_slice;
    logic signed [RES_W-1:0] due_value;
    bit                      in_busy   = 1'b0;
    bit                      in_fire   = 1'b0;
    bit                      in_calm   = 1'b0;
    int                      in_wait   = 0;
    bit                      out_fire  = 1'b0;
    bit                      out_calm  = 1'b0;
    int                      out_wait  = 0;
    bit                      hold_req  = 1'b0;
    int                      hold_left = 0;

    int fail_count    = 0;
    int slices_taken  = 0;
    int rows_checked  = 0;
    int settings_used = 0;

    function automatic logic signed [RES_W-1:0] clamp_result(input logic [127:0] mag,
                                                            input bit neg);
        logic signed [RES_W-1:0] r;
        if (mag > SAT_MAX)
            mag = SAT_MAX;
        r = mag[RES_W-1:0];
        return neg ? -r : r;
    endfunction

    function automatic logic signed [RES_W-1:0] round_q24(input longint v);
        logic [127:0] m;
        m = (v < 0) ? 128'(-v) : 128'(v);
        return clamp_result((m + (128'd1 << 23)) >> FRAC_W, v < 0);
    endfunction

    function automatic logic signed [RES_W-1:0] round_q48(input longint v,
                                                         input logic signed [SLOPE_W-1:0] k);
        logic signed [127:0] wide_v;
        logic signed [127:0] wide_k;
        logic signed [127:0] p;
        logic [127:0]        m;
        wide_v = v;
        wide_k = k;
        p = wide_v * wide_k;
        m = (p < 0) ? -p : p;
        return clamp_result((m + (128'd1 << 47)) >> (2 * FRAC_W), p < 0);
    endfunction

    // accumulate one slice, requantize at row end
    function automatic void dot_requant(input t_slice s);
        logic [ACC_W-1:0]        sum;
        logic signed [ACC_W-1:0] prod;
        longint                  v;
        logic signed [RES_W-1:0] r;
        sum = acc_m;
        for (int i = 0; i < LANES; i++) begin
            prod = $signed(s.mat[i]) * $signed(s.vec[i]);
            sum = sum + prod;
        end
        if (!s.row_end) begin
            acc_m = sum;
            return;
        end
        acc_m = '0;
        v = longint'($signed(sum)) * longint'(s.scale);
        if (bias_en_m)
            v = v + longint'(s.bias);
        case (act_m)
            ACT_RELU: begin
                if (v < 0)
                    v = 0;
                r = round_q24(v);
            end
            ACT_RELU6: begin
                if (v < 0)
                    v = 0;
                if (v > longint'(six_m))
                    v = longint'(six_m);
                r = round_q24(v);
            end
            ACT_LEAKY: begin
                r = (v < 0) ? round_q48(v, slope_m) : round_q24(v);
            end
            default: begin
                r = round_q24(v);
            end
        endcase
        row_results_due.push_back(r);
    endfunction

    // input side: wait drawn after each transaction, calm stretches without gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_busy = 1'b0;
            in_wait = 0;
        end else begin
            if (in_busy && in_fire) begin
                in_busy = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    in_calm = !in_calm;
                in_wait = in_calm ? 0 : $urandom_range(0, 11);
            end
            if (!in_busy) begin
                if (in_wait > 0)
                    in_wait--;
                else if (pending_slices.size() != 0) begin
                    cur_slice = pending_slices.pop_front();
                    in_busy = 1'b1;
                end
            end
        end
        in_ch.valid     <= in_busy;
        in_ch.mat_elem0 <= cur_slice.mat[0];
        in_ch.mat_elem1 <= cur_slice.mat[1];
        in_ch.mat_elem2 <= cur_slice.mat[2];
        in_ch.mat_elem3 <= cur_slice.mat[3];
        in_ch.vec_elem0 <= cur_slice.vec[0];
        in_ch.vec_elem1 <= cur_slice.vec[1];
        in_ch.vec_elem2 <= cur_slice.vec[2];
        in_ch.vec_elem3 <= cur_slice.vec[3];
        in_ch.row_end   <= cur_slice.row_end;
        in_ch.row_scale <= cur_slice.scale;
        in_ch.row_bias  <= cur_slice.bias;
    end

    // output side
    always @(negedge i_clk) begin
        if (out_fire) begin
            if ($urandom_range(0, 49) == 0)
                out_calm = !out_calm;
            out_wait = out_calm ? 0 : $urandom_range(0, 11);
        end else if (out_wait > 0) begin
            out_wait--;
        end
        out_ch.ready <= (out_wait == 0) && (hold_left == 0);
    end

    // long hold-off on the output, counted on its own
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 600;
            hold_req  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    always @(posedge i_clk) begin
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_fire) begin
            seen_slice.mat[0]  = in_ch.mat_elem0;
            seen_slice.mat[1]  = in_ch.mat_elem1;
            seen_slice.mat[2]  = in_ch.mat_elem2;
            seen_slice.mat[3]  = in_ch.mat_elem3;
            seen_slice.vec[0]  = in_ch.vec_elem0;
            seen_slice.vec[1]  = in_ch.vec_elem1;
            seen_slice.vec[2]  = in_ch.vec_elem2;
            seen_slice.vec[3]  = in_ch.vec_elem3;
            seen_slice.row_end = in_ch.row_end;
            seen_slice.scale   = in_ch.row_scale;
            seen_slice.bias    = in_ch.row_bias;
            dot_requant(seen_slice);
            slices_taken++;
        end
    end

    always @(posedge i_clk) begin
        out_fire = i_rst_n && out_ch.valid && out_ch.ready;
        if (out_fire) begin
            if (row_results_due.size() == 0) begin
                $error("result_value: no transaction expected, got %0d", out_ch.result_value);
                fail_count++;
            end else begin
                due_value = row_results_due.pop_front();
                if (out_ch.result_value !== due_value) begin
                    $error("result_value: expected %0d, got %0d", due_value,
                           out_ch.result_value);
                    fail_count++;
                end
                rows_checked++;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BIAS_EN: bias_en_m = value[0];
            REG_ACT:     act_m     = t_act'(value[1:0]);
            REG_SIX:     six_m     = value[SIX_W-1:0];
            REG_SLOPE:   slope_m   = value;
            default: ;
        endcase
    endtask

    function automatic void add_slice(input logic [31:0] m, input logic [31:0] vv,
                                      input bit last, input logic [SCALE_W-1:0] k,
                                      input logic [BIAS_W-1:0] b);
        t_slice s;
        s.mat     = m;
        s.vec     = vv;
        s.row_end = last;
        s.scale   = k;
        s.bias    = b;
        pending_slices.push_back(s);
    endfunction

    function automatic logic [ELEM_W-1:0] draw_elem();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'h7f;
            2:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [SCALE_W-1:0] draw_scale();
        logic signed [SCALE_W-1:0] k;
        k = $urandom;
        return k >>> (($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(10, 20));
    endfunction

    function automatic logic signed [BIAS_W-1:0] draw_bias();
        logic signed [BIAS_W-1:0] b;
        b = {8'($urandom), 32'($urandom)};
        return b >>> (($urandom_range(0, 3) == 0) ? $urandom_range(0, 39)
                                                  : $urandom_range(8, 20));
    endfunction

    function automatic void gen_rows(input int n_items, input int max_len);
        int     left;
        int     len;
        t_slice s;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 40)
                                               : $urandom_range(1, max_len);
            for (int j = 0; j < len; j++) begin
                for (int i = 0; i < LANES; i++) begin
                    s.mat[i] = draw_elem();
                    s.vec[i] = draw_elem();
                end
                s.row_end = (j == len - 1);
                s.scale   = draw_scale();
                s.bias    = draw_bias();
                pending_slices.push_back(s);
            end
            left -= len;
        end
    endfunction

    task automatic drain();
        int guard;
        while (pending_slices.size() != 0 || in_busy)
            @(posedge i_clk);
        guard = 0;
        while (row_results_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (row_results_due.size() != 0) begin
            $error("result_value: %0d rows never produced a transaction",
                   row_results_due.size());
            fail_count++;
            row_results_due.delete();
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_phase(input bit bias_on, input t_act act, input logic [31:0] six,
                             input logic [31:0] slope, input int n_items, input int max_len,
                             input bit long_hold);
        // junk in the unused upper bits must be dropped by the block
        write_reg(REG_BIAS_EN, ($urandom & 32'hffff_fffe) | 32'(bias_on));
        write_reg(REG_ACT, ($urandom & 32'hffff_fffc) | 32'(act));
        write_reg(REG_SIX, six);
        write_reg(REG_SLOPE, slope);
        settings_used++;
        if (long_hold)
            hold_req = 1'b1;
        add_slice(32'h0000_00fd, 32'h0000_0001, 1'b1, 32'h0100_0000, 40'h00_0080_0000);
        add_slice(32'h0000_0003, 32'h0000_0001, 1'b1, 32'h0100_0000, 40'h00_0080_0000);
        gen_rows(n_items, max_len);
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.mat_elem0 = '0;
        in_ch.mat_elem1 = '0;
        in_ch.mat_elem2 = '0;
        in_ch.mat_elem3 = '0;
        in_ch.vec_elem0 = '0;
        in_ch.vec_elem1 = '0;
        in_ch.vec_elem2 = '0;
        in_ch.vec_elem3 = '0;
        in_ch.row_end   = 1'b0;
        in_ch.row_scale = '0;
        in_ch.row_bias  = '0;
        out_ch.ready    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);

        // reset settings: no bias, no activation
        add_slice(32'h8080_8080, 32'h8080_8080, 1'b0, '0, '0);
        add_slice(32'h8080_8080, 32'h8080_8080, 1'b1, 32'h7fff_ffff, 40'h7f_ffff_ffff);
        add_slice(32'h8080_8080, 32'h7f7f_7f7f, 1'b1, 32'h7fff_ffff, 40'h80_0000_0000);
        add_slice(32'h7f7f_7f7f, 32'h7f7f_7f7f, 1'b1, 32'h8000_0000, '0);
        add_slice(32'h0000_0000, 32'h0000_0000, 1'b1, $urandom, draw_bias());
        add_slice(32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0080_0000, '0);
        add_slice(32'h0000_00ff, 32'h0000_0001, 1'b1, 32'h0080_0000, '0);
        add_slice(32'h0000_0001, 32'h0000_0001, 1'b1, 32'h007f_ffff, '0);
        add_slice(32'h0000_007f, 32'h0000_0001, 1'b1, 32'h0100_0000, '0);
        add_slice(32'h0000_0040, 32'h0000_0002, 1'b1, 32'h0100_0000, '0);
        add_slice(32'h0000_00c0, 32'h0000_0002, 1'b1, 32'h0100_0000, '0);
        add_slice(32'hffff_ffff, 32'h0101_0101, 1'b1, 32'h0100_0000, '0);
        drain();

        run_phase(1'b1, ACT_NONE, 32'h0, 32'h0, 140, 8, 1'b0);
        run_phase(1'b1, ACT_RELU, $urandom, $urandom, 140, 8, 1'b0);
        run_phase(1'b0, ACT_RELU6, 32'h0, $urandom, 80, 6, 1'b0);
        run_phase(1'b1, ACT_RELU6, 32'hffff_ffff, $urandom, 80, 2, 1'b1);
        run_phase(1'b1, ACT_RELU6, $urandom_range(0, 32'h0a00_0000), 32'h0, 140, 8, 1'b0);
        run_phase(1'b0, ACT_LEAKY, $urandom, 32'h0, 100, 8, 1'b0);
        run_phase(1'b1, ACT_LEAKY, $urandom, 32'h8000_0000, 100, 8, 1'b0);
        run_phase(1'b1, ACT_LEAKY, $urandom, 32'h7fff_ffff, 100, 8, 1'b0);
        run_phase(1'b1, ACT_LEAKY, $urandom, $urandom >> $urandom_range(4, 12), 140, 8, 1'b0);
        run_phase(1'b0, ACT_NONE, $urandom, $urandom, 80, 8, 1'b0);

        $display("covered %0d slice transactions and %0d finished rows", slices_taken,
                 rows_checked);
        $display("over %0d register settings plus reset values, one long output hold-off",
                 settings_used);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d rows still due", row_results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
